[rtl/cbgc_pkg.sv]
// ----------------------------------------------------------------------------
// cbgc_pkg
// shared constants and types for the column border gradient counter
// ----------------------------------------------------------------------------
package cbgc_pkg;

  localparam int unsigned MAX_WIDTH = 2048;
  localparam int unsigned COL_W     = $clog2(MAX_WIDTH);
  localparam int unsigned PIX_W     = 24;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned NUM_CHAN  = 3;
  localparam int unsigned COUNT_W   = 12;
  localparam int unsigned ADDR_W    = 3;
  localparam int unsigned DATA_W    = 32;

  // register indexes, taken from paddr[2]
  localparam logic REG_THRESHOLD  = 1'b0;
  localparam logic REG_UPPER_DARK = 1'b1;

  // one column entry: row above, per-channel max step, black-edge flags
  typedef struct packed {
    logic [PIX_W-1:0]    pix;
    logic [PIX_W-1:0]    grad;
    logic [NUM_CHAN-1:0] flag;
  } col_entry_t;

  // stage 1 control handed to the merge stage
  typedef struct packed {
    logic fire;
    logic last;
    logic eor;
  } cbgc_ctrl_t;

endpackage

[rtl/cbgc_lane.sv]
// ----------------------------------------------------------------------------
// cbgc_lane
// one colour channel: step update, black-edge flag and threshold judgement
// ----------------------------------------------------------------------------
module cbgc_lane
  import cbgc_pkg::*;
(
  input  logic [CHAN_W-1:0] above_i,
  input  logic [CHAN_W-1:0] pix_i,
  input  logic [CHAN_W-1:0] grad_i,
  input  logic              flag_i,
  input  logic              first_row_i,
  input  logic              upper_dark_i,
  input  logic [CHAN_W-1:0] thr_i,
  output logic [CHAN_W-1:0] grad_o,
  output logic              flag_o,
  output logic              ok_o
);

  logic [CHAN_W-1:0] dark;
  logic [CHAN_W-1:0] light;
  logic [CHAN_W-1:0] diff;

  always_comb begin
    dark  = upper_dark_i ? above_i : pix_i;
    light = upper_dark_i ? pix_i : above_i;
    diff  = light - dark;
    if (first_row_i) begin
      grad_o = '0;
      flag_o = 1'b0;
    end else begin
      flag_o = flag_i | ((dark == '0) && (light != '0));
      grad_o = ((light > dark) && (diff > grad_i)) ? diff : grad_i;
    end
    ok_o = flag_o || (grad_o >= thr_i);
  end

endmodule

[rtl/cbgc_merge.sv]
// ----------------------------------------------------------------------------
// cbgc_merge
// combines the lane verdicts, keeps the running count and the output register
// ----------------------------------------------------------------------------
module cbgc_merge
  import cbgc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cbgc_ctrl_t         ctrl_i,
  input  logic [NUM_CHAN-1:0] ok_i,
  input  logic               stall_i,
  output logic               out_free_o,
  output logic               valid_o,
  output logic [COUNT_W-1:0] border_count_o
);

  logic [COUNT_W-1:0] total_d, total_q;
  logic [COUNT_W-1:0] count_d, count_q;
  logic               valid_d, valid_q;
  logic               emit;
  logic [COUNT_W-1:0] total_inc;

  assign out_free_o = !valid_q || !stall_i;
  assign emit       = ctrl_i.fire && ctrl_i.last && ctrl_i.eor;

  always_comb begin
    total_inc = total_q;
    // saturate at the top of the count range
    if (ctrl_i.fire && ctrl_i.last && (&ok_i) && (total_q != '1)) begin
      total_inc = total_q + COUNT_W'(1);
    end
    total_d = emit ? '0 : total_inc;
    count_d = emit ? total_inc : count_q;
    valid_d = emit ? 1'b1 : (valid_q && stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      valid_q <= 1'b0;
    end else begin
      total_q <= total_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q <= count_d;
  end

  assign valid_o        = valid_q;
  assign border_count_o = count_q;

endmodule

[rtl/column_border_gradient_counter.sv]
// ----------------------------------------------------------------------------
// column_border_gradient_counter
// counts columns with a strong vertical edge or black edge on every channel
// ----------------------------------------------------------------------------
// Pixels come in raster order on the input channel (valid_i / stall_o), with
// end_of_row_i on the last pixel of a row and last_row_i on every pixel of the
// final row. On the pixel carrying both, one border_count_o item leaves on the
// output channel (valid_o / stall_i); no other pixel produces a result.
// Throughput is one pixel per clock unless stalled: each pixel does one read
// of the column store in the accept cycle and one write when stage 1 fires,
// with a bypass when consecutive pixels land on the same column. The frame's
// final pixel, leaving stage 1, sets the register behind valid_o. While a
// count waits in the output register the block keeps accepting pixels; only a
// second frame end stalls stage 1, and stall_o then rises. threshold_color
// (address 0) and the darker-side select (address 4) are written over the APB
// port while the block is idle, a duty of the user that the block does not
// enforce. Reset clears the counters and row state and makes the upper row
// the darker side; the column store is not cleared and needs no sweep, since
// the first row of every frame writes every column it later reads.
// ----------------------------------------------------------------------------
module column_border_gradient_counter
  import cbgc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // pixel input
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [PIX_W-1:0]   pixel_i,
  input  logic               end_of_row_i,
  input  logic               last_row_i,
  // count output
  output logic               valid_o,
  input  logic               stall_i,
  output logic [COUNT_W-1:0] border_count_o,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  // configuration registers
  logic [PIX_W-1:0] thr_q;
  logic             upper_dark_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q        <= '0;
      upper_dark_q <= 1'b1;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_THRESHOLD:  thr_q        <= pwdata[PIX_W-1:0];
        REG_UPPER_DARK: upper_dark_q <= pwdata[0];
        default:        thr_q        <= thr_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_THRESHOLD:  prdata = {{(DATA_W-PIX_W){1'b0}}, thr_q};
      REG_UPPER_DARK: prdata = {{(DATA_W-1){1'b0}}, upper_dark_q};
      default:        prdata = '0;
    endcase
  end

  // stage 0: column and row tracking
  logic             accept;
  logic [COL_W-1:0] col_d, col_q;
  logic             phase_d, phase_q;

  assign accept = valid_i && !stall_o;

  always_comb begin
    col_d   = col_q;
    phase_d = phase_q;
    if (accept) begin
      if (end_of_row_i) begin
        col_d   = '0;
        phase_d = !last_row_i;
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      phase_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      phase_q <= phase_d;
    end
  end

  // stage 1 registers
  logic             s1_valid_d, s1_valid_q;
  logic             s1_fire;
  logic             out_free;
  logic [PIX_W-1:0] s1_pix_q;
  logic             s1_eor_q;
  logic             s1_last_q;
  logic             s1_first_q;
  logic [COL_W-1:0] s1_col_q;

  assign s1_fire = s1_valid_q && (!(s1_last_q && s1_eor_q) || out_free);
  assign stall_o = s1_valid_q && !s1_fire;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q   <= pixel_i;
      s1_eor_q   <= end_of_row_i;
      s1_last_q  <= last_row_i;
      s1_first_q <= !phase_q;
      s1_col_q   <= col_q;
    end
  end

  // column store with a bypass for a write landing on the column being read
  col_entry_t mem [MAX_WIDTH];
  col_entry_t rd_q;
  col_entry_t wr_data;
  col_entry_t byp_q;
  col_entry_t cur;
  logic       byp_hit_q;

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      mem[s1_col_q] <= wr_data;
    end
    if (accept) begin
      rd_q <= mem[col_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_hit_q <= 1'b0;
    end else if (accept) begin
      byp_hit_q <= s1_fire && (s1_col_q == col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byp_q <= wr_data;
    end
  end

  assign cur = byp_hit_q ? byp_q : rd_q;

  // one lane per colour channel
  logic [NUM_CHAN-1:0] ok;

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_lane
    localparam int unsigned Hi = PIX_W - 1 - CHAN_W * c;
    localparam int unsigned Fb = NUM_CHAN - 1 - c;

    cbgc_lane u_lane (
      .above_i      (cur.pix[Hi -: CHAN_W]),
      .pix_i        (s1_pix_q[Hi -: CHAN_W]),
      .grad_i       (cur.grad[Hi -: CHAN_W]),
      .flag_i       (cur.flag[Fb]),
      .first_row_i  (s1_first_q),
      .upper_dark_i (upper_dark_q),
      .thr_i        (thr_q[Hi -: CHAN_W]),
      .grad_o       (wr_data.grad[Hi -: CHAN_W]),
      .flag_o       (wr_data.flag[Fb]),
      .ok_o         (ok[Fb])
    );
  end

  assign wr_data.pix = s1_pix_q;

  // merge stage
  cbgc_ctrl_t ctrl;

  assign ctrl.fire = s1_fire;
  assign ctrl.last = s1_last_q;
  assign ctrl.eor  = s1_eor_q;

  cbgc_merge u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .ok_i           (ok),
    .stall_i        (stall_i),
    .out_free_o     (out_free),
    .valid_o        (valid_o),
    .border_count_o (border_count_o)
  );

  // checks
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> s1_valid_q)
    else $error("stall raised with stage 1 empty");

  a_bypass_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s1_fire && (s1_col_q == col_q)) |=> byp_hit_q)
    else $error("bypass missed a same-column write");

  a_emit_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_last_q && s1_eor_q) |=> valid_o)
    else $error("frame end did not produce a count");

  a_row_end_resets_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && end_of_row_i) |=> (col_q == '0))
    else $error("column position not cleared at row end");

endmodule

[tb/border_count_checker.sv]
// ----------------------------------------------------------------------------
// border_count_checker
// predicts and checks the border counts of the column border gradient counter
// ----------------------------------------------------------------------------
// Watches the pixel channel, the count channel and the register port. Every
// accepted pixel goes through a line-store model of the block. On the frame's
// final pixel that model queues the count it expects. Each accepted count is
// compared with the oldest queued one.
// ----------------------------------------------------------------------------
module border_count_checker
  import cbgc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // pixel channel
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [PIX_W-1:0]   pixel_i,
  input  logic               end_of_row_i,
  input  logic               last_row_i,
  // count channel
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [COUNT_W-1:0] border_count_i,
  // register port
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic               pready_i,
  input  logic [ADDR_W-1:0]  paddr_i,
  input  logic [DATA_W-1:0]  pwdata_i,
  // status for the stimulus side
  output int unsigned        mismatches_o,
  output int unsigned        pending_o
);

  logic [PIX_W-1:0]    row_above [MAX_WIDTH];
  logic [PIX_W-1:0]    step_max [MAX_WIDTH];
  logic [NUM_CHAN-1:0] black_seen [MAX_WIDTH];
  logic [COL_W-1:0]    col;
  logic                in_later_row;
  logic [COUNT_W-1:0]  running_total;
  logic [PIX_W-1:0]    thresh;
  logic                dark_is_top;
  logic [COUNT_W-1:0]  counts_due [$];
  logic [COUNT_W-1:0]  want;
  int unsigned         mismatches = 0;

  assign mismatches_o = mismatches;

  task automatic report_mismatch(input string msg);
    $display("[%0t] count check: %s", $realtime, msg);
    mismatches++;
  endtask

  // one pixel through the line store, steps and flags, then the running count
  task automatic take_pixel(input logic [PIX_W-1:0] pix, input logic eor, input logic last);
    logic [PIX_W-1:0]    dark;
    logic [PIX_W-1:0]    light;
    logic [PIX_W-1:0]    grad;
    logic [NUM_CHAN-1:0] flags;
    logic [CHAN_W-1:0]   d;
    logic [CHAN_W-1:0]   l;
    logic                is_border;
    grad  = '0;
    flags = '0;
    if (in_later_row) begin
      dark  = dark_is_top ? row_above[col] : pix;
      light = dark_is_top ? pix : row_above[col];
      grad  = step_max[col];
      flags = black_seen[col];
      for (int k = 0; k < NUM_CHAN; k++) begin
        d = dark[CHAN_W*k +: CHAN_W];
        l = light[CHAN_W*k +: CHAN_W];
        if (d == '0 && l != '0) flags[k] = 1'b1;
        if (l > d && CHAN_W'(l - d) > grad[CHAN_W*k +: CHAN_W]) begin
          grad[CHAN_W*k +: CHAN_W] = l - d;
        end
      end
    end
    step_max[col]   = grad;
    black_seen[col] = flags;
    row_above[col]  = pix;

    if (last) begin
      is_border = 1'b1;
      for (int k = 0; k < NUM_CHAN; k++) begin
        if (!flags[k] && grad[CHAN_W*k +: CHAN_W] < thresh[CHAN_W*k +: CHAN_W]) begin
          is_border = 1'b0;
        end
      end
      // saturating count
      if (is_border && running_total != '1) running_total = running_total + 1'b1;
    end

    if (eor) begin
      col = '0;
      if (last) begin
        counts_due.push_back(running_total);
        running_total = '0;
        in_later_row  = 1'b0;
      end else begin
        in_later_row = 1'b1;
      end
    end else begin
      col = col + 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col           = '0;
      in_later_row  = 1'b0;
      running_total = '0;
      thresh        = '0;
      dark_is_top   = 1'b1;
      counts_due.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (counts_due.size() == 0) begin
          report_mismatch($sformatf("count %0d arrived with none outstanding", border_count_i));
        end else begin
          want = counts_due.pop_front();
          if (border_count_i !== want) begin
            report_mismatch($sformatf("border_count %0d, predicted %0d", border_count_i, want));
          end
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[ADDR_W-1] == REG_UPPER_DARK) dark_is_top = pwdata_i[0];
        else thresh = pwdata_i[PIX_W-1:0];
      end
      if (in_valid_i && !in_stall_i) take_pixel(pixel_i, end_of_row_i, last_row_i);
      pending_o <= counts_due.size();
    end
  end

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the column border gradient counter
// ----------------------------------------------------------------------------
// Feeds short directed frames, then random phases of frames and broken pixel
// runs under several threshold and dark-side settings, with random gaps on
// both channels and one long output hold-off. The checker instance does all
// prediction and comparison.
// ----------------------------------------------------------------------------
module tb;
  import cbgc_pkg::*;

  localparam int unsigned IDLE_LIMIT    = 4000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned NUM_PHASES    = 8;
  localparam int unsigned PHASE_PIXELS  = 195;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               valid_i;
  logic               stall_o;
  logic [PIX_W-1:0]   pixel_i;
  logic               end_of_row_i;
  logic               last_row_i;
  logic               valid_o;
  logic               stall_i;
  logic [COUNT_W-1:0] border_count_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  int unsigned mismatches;
  int unsigned counts_pending;
  int unsigned tx_gap_max = 17;
  int unsigned rx_gap_max = 17;
  bit          long_hold_req = 1'b0;
  int unsigned quiet_cycles = 0;

  // where the block stands in the frame, so that no later row reads a column
  // that was never written since reset
  int unsigned gen_col = 0;
  bit          gen_later = 1'b0;
  int unsigned filled_cols = 0;
  int unsigned pixels_sent = 0;

  always #5 clk_i = ~clk_i;

  column_border_gradient_counter dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (valid_i),
    .stall_o        (stall_o),
    .pixel_i        (pixel_i),
    .end_of_row_i   (end_of_row_i),
    .last_row_i     (last_row_i),
    .valid_o        (valid_o),
    .stall_i        (stall_i),
    .border_count_o (border_count_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  border_count_checker chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (valid_i),
    .in_stall_i     (stall_o),
    .pixel_i        (pixel_i),
    .end_of_row_i   (end_of_row_i),
    .last_row_i     (last_row_i),
    .out_valid_i    (valid_o),
    .out_stall_i    (stall_i),
    .border_count_i (border_count_o),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .pready_i       (pready),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .mismatches_o   (mismatches),
    .pending_o      (counts_pending)
  );

  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i) || (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // count receiver: stall cycles are only spent while a count is offered
  initial begin
    int unsigned hold;
    hold    = 0;
    stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (valid_o && !stall_i) hold = $urandom_range(0, rx_gap_max);
      else if (valid_o && hold != 0) hold--;
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_i <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk_i);
      end
      stall_i <= (hold != 0);
    end
  end

  // channel values biased towards black, full scale and tiny steps
  function automatic logic [CHAN_W-1:0] rand_channel();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return CHAN_W'($urandom_range(1, 3));
      default: return CHAN_W'($urandom);
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    return {rand_channel(), rand_channel(), rand_channel()};
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic eor, input logic last);
    int unsigned gap;
    gap = $urandom_range(0, tx_gap_max);
    @(negedge clk_i);
    if (gap != 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    valid_i      <= 1'b1;
    pixel_i      <= pix;
    end_of_row_i <= eor;
    last_row_i   <= last;
    do @(posedge clk_i); while (stall_o);
    if (gen_col + 1 > filled_cols) filled_cols = gen_col + 1;
    if (eor) begin
      gen_col   = 0;
      gen_later = !last;
    end else begin
      gen_col = (gen_col + 1) % MAX_WIDTH;
    end
    pixels_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    valid_i <= 1'b0;
    @(posedge clk_i);
    while (counts_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic index, input logic [DATA_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // later rows may be ragged, but never reach past the written columns
  task automatic send_frame(input int unsigned width, input int unsigned rows, input bit ragged);
    int unsigned len;
    if (gen_later || gen_col != 0) send_pixel(rand_pixel(), 1'b1, 1'b1);
    for (int unsigned r = 0; r < rows; r++) begin
      len = width;
      if (r != 0 && ragged) begin
        len = $urandom_range(1, (filled_cols < width + 6) ? filled_cols : width + 6);
      end
      for (int unsigned x = 0; x < len; x++) begin
        send_pixel(rand_pixel(), x == len - 1, r == rows - 1);
      end
    end
  endtask

  initial begin
    int unsigned phase_start;
    logic        noise_eor;
    valid_i      = 1'b0;
    pixel_i      = '0;
    end_of_row_i = 1'b0;
    last_row_i   = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: one-row image, every column counts at zero threshold
    send_pixel(24'h000000, 1'b0, 1'b1);
    send_pixel(24'hFFFFFF, 1'b1, 1'b1);
    // black edge one way, full step the other
    send_pixel(24'h000000, 1'b0, 1'b0);
    send_pixel(24'hFFFFFF, 1'b1, 1'b0);
    send_pixel(24'hFFFFFF, 1'b0, 1'b1);
    send_pixel(24'h000000, 1'b1, 1'b1);
    // stray last_row flag, a plain row end, then the frame end
    send_pixel(24'h808080, 1'b0, 1'b1);
    send_pixel(24'h7F7F7F, 1'b1, 1'b0);
    send_pixel(24'h01FF00, 1'b1, 1'b1);
    wait_idle();
    reg_write(REG_THRESHOLD, 32'h00FF_FFFF);
    reg_write(REG_UPPER_DARK, 32'd0);
    send_pixel(24'h000000, 1'b0, 1'b0);
    send_pixel(24'hFFFFFF, 1'b1, 1'b0);
    send_pixel(24'hFFFFFF, 1'b0, 1'b1);
    send_pixel(24'h000000, 1'b1, 1'b1);
    send_pixel(24'h00FF01, 1'b1, 1'b0);
    send_pixel(24'hFF0000, 1'b1, 1'b1);

    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      reg_write(REG_THRESHOLD, (p == 0) ? 32'd0 : (p == 1) ? 32'h00FF_FFFF : {8'd0, rand_pixel()});
      reg_write(REG_UPPER_DARK, p % 2);
      tx_gap_max = (p == 3) ? 0 : 17;
      rx_gap_max = (p == 3) ? 0 : 17;
      if (p == 5) begin
        // hold the count channel while frames keep ending, so the block backs up
        long_hold_req = 1'b1;
        tx_gap_max    = 0;
        repeat (24) send_frame(1, 1, 1'b0);
        tx_gap_max    = 17;
      end
      phase_start = pixels_sent;
      while (pixels_sent - phase_start < PHASE_PIXELS) begin
        if ($urandom_range(0, 4) == 0) begin
          // broken run: random row ends and last_row flags
          repeat ($urandom_range(4, 12)) begin
            noise_eor = ($urandom_range(0, 5) == 0) || (gen_later && gen_col + 1 >= filled_cols);
            send_pixel(rand_pixel(), noise_eor, $urandom_range(0, 3) == 0);
          end
        end else begin
          send_frame(($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10),
                     $urandom_range(1, 4), $urandom_range(0, 2) == 0);
        end
      end
    end

    wait_idle();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[files.f]
rtl/cbgc_pkg.sv
rtl/cbgc_lane.sv
rtl/cbgc_merge.sv
rtl/column_border_gradient_counter.sv
tb/border_count_checker.sv
tb/tb.sv
